// ----- rtl/obpl_pkg.sv -----
// Shared types and constants for the order book price-level block.
// Depends on nothing; every other file imports it.
package obpl_pkg;

    localparam int PL_DEFAULT = 16;  // default levels per side
    localparam int PW         = 32;  // price width in ticks
    localparam int QW         = 32;  // size width
    localparam int CNT_OUT_W  = 5;   // width of the level count result fields

    // event opcodes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_MODIFY = 2'd1,
        OP_CANCEL = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // per-side update applied to the cell chain
    typedef enum logic [2:0] {
        MODE_NONE = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_MOD  = 3'd2,
        MODE_SUB  = 3'd3,
        MODE_DEL  = 3'd4,
        MODE_INS  = 3'd5
    } t_mode;

    // one price level
    typedef struct packed {
        logic [PW-1:0] price;
        logic [QW-1:0] size;
    } t_lvl;

    // compare results registered in each cell
    typedef struct packed {
        logic match;  // cell holds the event price
        logic rem;    // ... and a cancel of this quantity empties it
    } t_cell_flags;

    // one result beat
    typedef struct packed {
        logic [PW-1:0]        best_bid_price;
        logic [QW-1:0]        best_bid_size;
        logic [PW-1:0]        best_ask_price;
        logic [QW-1:0]        best_ask_size;
        logic [PW:0]          mid_twice;
        logic [CNT_OUT_W-1:0] bid_level_count;
        logic [CNT_OUT_W-1:0] ask_level_count;
        logic                 table_full;
        logic [31:0]          sequence_res;
        logic [31:0]          events_total;
    } t_res;

endpackage

// ----- rtl/obpl_evt_if.sv -----
// Event channel: valid/ready handshake with the order event payload.
// Depends on obpl_pkg.
interface obpl_evt_if import obpl_pkg::*; ;
    logic          valid;
    logic          ready;
    logic [1:0]    op;
    logic          side;
    logic [PW-1:0] price;
    logic [QW-1:0] quantity;

    modport source (output valid, op, side, price, quantity, input ready);
    modport sink   (input valid, op, side, price, quantity, output ready);
endinterface

// ----- rtl/obpl_res_if.sv -----
// Result channel: valid/ready handshake with the top-of-book payload.
// Depends on obpl_pkg.
interface obpl_res_if import obpl_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [PW-1:0]        best_bid_price;
    logic [QW-1:0]        best_bid_size;
    logic [PW-1:0]        best_ask_price;
    logic [QW-1:0]        best_ask_size;
    logic [PW:0]          mid_twice;
    logic [CNT_OUT_W-1:0] bid_level_count;
    logic [CNT_OUT_W-1:0] ask_level_count;
    logic                 table_full;
    logic [31:0]          sequence_res;
    logic [31:0]          events_total;

    modport source (output valid, best_bid_price, best_bid_size, best_ask_price,
                    best_ask_size, mid_twice, bid_level_count, ask_level_count,
                    table_full, sequence_res, events_total, input ready);
    modport sink   (input valid, best_bid_price, best_bid_size, best_ask_price,
                    best_ask_size, mid_twice, bid_level_count, ask_level_count,
                    table_full, sequence_res, events_total, output ready);
endinterface

// ----- rtl/obpl_cell.sv -----
// One price-level cell: holds a level, compares it with the event and
// shifts to/from its neighbours. Depends on obpl_pkg.
module obpl_cell import obpl_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter bit ASK = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmp,
    input  t_mode         i_mode,
    input  logic [CW-1:0] i_cnt,
    input  logic [PW-1:0] i_cmp_price,
    input  logic [QW-1:0] i_cmp_qty,
    input  logic [PW-1:0] i_upd_price,
    input  logic [QW-1:0] i_upd_qty,
    input  t_lvl          i_left,
    input  logic          i_left_beh,
    input  t_lvl          i_right,
    output t_lvl          o_lvl,
    output logic          o_beh,
    output t_lvl          o_nxt,
    output t_cell_flags   o_flags
);

    t_lvl        r_lvl, n_lvl;
    t_cell_flags r_flags;
    logic        r_beh;   // empty, or event price ranks strictly ahead of this level
    logic        r_nb;    // held and event price ranks ahead of or equal to it
    logic        held, eq, ahead;
    logic [QW:0] sum;

    // compare against the incoming beat
    always_comb begin
        held  = (i_cnt > CW'(IDX));
        eq    = (r_lvl.price == i_cmp_price);
        ahead = ASK ? (i_cmp_price < r_lvl.price) : (i_cmp_price > r_lvl.price);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_beh   <= 1'b0;
            r_nb    <= 1'b0;
        end else if (i_cmp) begin
            r_flags.match <= held && eq;
            r_flags.rem   <= held && eq && (i_cmp_qty >= r_lvl.size);
            r_beh         <= !held || ahead;
            r_nb          <= held && (eq || ahead);
        end
    end

    // update: in-place size change, shift left on removal, shift right on insert
    always_comb begin
        sum   = {1'b0, r_lvl.size} + {1'b0, i_upd_qty};
        n_lvl = r_lvl;
        case (i_mode)
            MODE_ADD: if (r_flags.match) n_lvl.size = sum[QW] ? '1 : sum[QW-1:0];
            MODE_MOD: if (r_flags.match) n_lvl.size = i_upd_qty;
            MODE_SUB: if (r_flags.match) n_lvl.size = r_lvl.size - i_upd_qty;
            MODE_DEL: if (r_nb) n_lvl = i_right;
            MODE_INS: begin
                if (r_beh) begin
                    if (i_left_beh) begin
                        n_lvl = i_left;
                    end else begin
                        n_lvl.price = i_upd_price;
                        n_lvl.size  = i_upd_qty;
                    end
                end
            end
            default: n_lvl = r_lvl;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lvl <= n_lvl;
    end

    assign o_lvl   = r_lvl;
    assign o_beh   = r_beh;
    assign o_nxt   = n_lvl;
    assign o_flags = r_flags;

endmodule

// ----- rtl/obpl_side.sv -----
// One side of the book: a chain of level cells plus the level count.
// Depends on obpl_pkg and obpl_cell.
module obpl_side import obpl_pkg::*; #(
    parameter int N   = PL_DEFAULT,
    parameter int CW  = 5,
    parameter bit ASK = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmp,
    input  logic          i_upd,
    input  logic          i_clr,
    input  t_op           i_op,
    input  logic [PW-1:0] i_cmp_price,
    input  logic [QW-1:0] i_cmp_qty,
    input  logic [PW-1:0] i_upd_price,
    input  logic [QW-1:0] i_upd_qty,
    output t_lvl          o_head,
    output logic [CW-1:0] o_cnt_nxt,
    output logic          o_full
);

    t_lvl          lvl [N];
    t_lvl          nxt [N];
    logic          beh [N];
    t_cell_flags   flg [N];
    logic [CW-1:0] r_cnt, n_cnt;
    logic          any_match, any_rem, at_cap;
    t_mode         mode;

    // cell chain
    for (genvar g = 0; g < N; g++) begin : g_cell
        t_lvl left_lvl, right_lvl;
        logic left_beh;
        if (g == 0) begin : g_first
            assign left_lvl = '0;
            assign left_beh = 1'b0;
        end else begin : g_mid
            assign left_lvl = lvl[g-1];
            assign left_beh = beh[g-1];
        end
        if (g == N - 1) begin : g_last
            assign right_lvl = lvl[g];
        end else begin : g_inner
            assign right_lvl = lvl[g+1];
        end
        obpl_cell #(.IDX(g), .CW(CW), .ASK(ASK)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmp       (i_cmp),
            .i_mode      (mode),
            .i_cnt       (r_cnt),
            .i_cmp_price (i_cmp_price),
            .i_cmp_qty   (i_cmp_qty),
            .i_upd_price (i_upd_price),
            .i_upd_qty   (i_upd_qty),
            .i_left      (left_lvl),
            .i_left_beh  (left_beh),
            .i_right     (right_lvl),
            .o_lvl       (lvl[g]),
            .o_beh       (beh[g]),
            .o_nxt       (nxt[g]),
            .o_flags     (flg[g])
        );
    end

    // at most one cell matches; gather the flags
    always_comb begin
        any_match = 1'b0;
        any_rem   = 1'b0;
        for (int k = 0; k < N; k++) begin
            any_match = any_match | flg[k].match;
            any_rem   = any_rem | flg[k].rem;
        end
    end

    // choose the chain operation
    always_comb begin
        at_cap = (r_cnt >= CW'(N));
        mode   = MODE_NONE;
        o_full = 1'b0;
        if (i_upd) begin
            if (any_match) begin
                unique case (i_op)
                    OP_ADD:    mode = MODE_ADD;
                    OP_MODIFY: mode = MODE_MOD;
                    OP_CANCEL: mode = any_rem ? MODE_DEL : MODE_SUB;
                    default:   mode = MODE_NONE;
                endcase
            end else if (i_op != OP_CANCEL) begin
                if (at_cap) o_full = 1'b1;
                else        mode   = MODE_INS;
            end
        end
    end

    // level count
    always_comb begin
        n_cnt = r_cnt;
        if (i_clr)                  n_cnt = '0;
        else if (mode == MODE_DEL)  n_cnt = r_cnt - CW'(1);
        else if (mode == MODE_INS)  n_cnt = r_cnt + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else          r_cnt <= n_cnt;
    end

    assign o_head    = nxt[0];
    assign o_cnt_nxt = n_cnt;

endmodule

// ----- rtl/order_book_price_levels.sv -----
// Flow: an accepted event beat is held and compared by the cells; then, in the update
// state, the cells shift or update and the result register loads and sets result valid.
// A result not yet taken holds off that update step, and no new event is taken until it is done.
// Reset: level counts, both event counters, state and result valid are cleared;
// level storage in the cells is not cleared and is only read below the count.
// Depends on obpl_pkg, obpl_evt_if, obpl_res_if and obpl_side.
module order_book_price_levels import obpl_pkg::*; #(
    parameter int PRICE_LEVELS = PL_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obpl_evt_if.sink    i_evt,
    obpl_res_if.source  o_res
);

    localparam int CW = $clog2(PRICE_LEVELS + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    t_state        r_state, n_state;
    t_op           r_op;
    logic          r_side;
    logic [PW-1:0] r_price;
    logic [QW-1:0] r_qty;
    logic [31:0]   r_seq, r_evt;
    logic          r_ovalid;
    t_res          r_res, n_res;
    logic          acc, fire, is_clr;
    t_lvl          bid_head, ask_head;
    logic [CW-1:0] bid_cnt, ask_cnt;
    logic          bid_full, ask_full;
    logic [31:0]   n_seq, n_evt;

    assign acc    = i_evt.valid && i_evt.ready;
    assign fire   = (r_state == S_UPD) && (!r_ovalid || o_res.ready);
    assign is_clr = (r_op == OP_CLEAR);
    assign i_evt.ready = (r_state == S_IDLE);

    // event hold register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op    <= t_op'(i_evt.op);
            r_side  <= i_evt.side;
            r_price <= i_evt.price;
            r_qty   <= i_evt.quantity;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (acc)  n_state = S_UPD;
            S_UPD:   if (fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // bid and ask chains
    obpl_side #(.N(PRICE_LEVELS), .CW(CW), .ASK(1'b0)) u_bid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmp       (acc && !i_evt.side),
        .i_upd       (fire && !is_clr && !r_side),
        .i_clr       (fire && is_clr),
        .i_op        (r_op),
        .i_cmp_price (i_evt.price),
        .i_cmp_qty   (i_evt.quantity),
        .i_upd_price (r_price),
        .i_upd_qty   (r_qty),
        .o_head      (bid_head),
        .o_cnt_nxt   (bid_cnt),
        .o_full      (bid_full)
    );

    obpl_side #(.N(PRICE_LEVELS), .CW(CW), .ASK(1'b1)) u_ask (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmp       (acc && i_evt.side),
        .i_upd       (fire && !is_clr && r_side),
        .i_clr       (fire && is_clr),
        .i_op        (r_op),
        .i_cmp_price (i_evt.price),
        .i_cmp_qty   (i_evt.quantity),
        .i_upd_price (r_price),
        .i_upd_qty   (r_qty),
        .o_head      (ask_head),
        .o_cnt_nxt   (ask_cnt),
        .o_full      (ask_full)
    );

    // counters and result assembly
    always_comb begin
        n_seq = is_clr ? 32'd0 : r_seq + 32'd1;
        n_evt = is_clr ? r_evt : r_evt + 32'd1;

        n_res                 = '0;
        n_res.best_bid_price  = (bid_cnt != '0) ? bid_head.price : '0;
        n_res.best_bid_size   = (bid_cnt != '0) ? bid_head.size  : '0;
        n_res.best_ask_price  = (ask_cnt != '0) ? ask_head.price : '0;
        n_res.best_ask_size   = (ask_cnt != '0) ? ask_head.size  : '0;
        n_res.mid_twice       = {1'b0, n_res.best_bid_price} + {1'b0, n_res.best_ask_price};
        n_res.bid_level_count = CNT_OUT_W'(bid_cnt);
        n_res.ask_level_count = CNT_OUT_W'(ask_cnt);
        n_res.table_full      = bid_full | ask_full;
        n_res.sequence_res    = n_seq;
        n_res.events_total    = n_evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seq    <= '0;
            r_evt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_seq    <= n_seq;
                r_evt    <= n_evt;
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (fire) r_res <= n_res;
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.best_bid_price  = r_res.best_bid_price;
    assign o_res.best_bid_size   = r_res.best_bid_size;
    assign o_res.best_ask_price  = r_res.best_ask_price;
    assign o_res.best_ask_size   = r_res.best_ask_size;
    assign o_res.mid_twice       = r_res.mid_twice;
    assign o_res.bid_level_count = r_res.bid_level_count;
    assign o_res.ask_level_count = r_res.ask_level_count;
    assign o_res.table_full      = r_res.table_full;
    assign o_res.sequence_res    = r_res.sequence_res;
    assign o_res.events_total    = r_res.events_total;

endmodule

// ----- rtl/obpl_check.sv -----
// Port-level checks for the order book block, bound to the top level.
// Depends on obpl_pkg and order_book_price_levels.
module obpl_check import obpl_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [PW-1:0]        i_bid_price,
    input logic [QW-1:0]        i_bid_size,
    input logic [PW-1:0]        i_ask_price,
    input logic [PW:0]          i_mid,
    input logic [CNT_OUT_W-1:0] i_bid_cnt,
    input logic [31:0]          i_seq
);

    // the mid sum always matches the best prices it is built from
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_mid == ({1'b0, i_bid_price} + {1'b0, i_ask_price})))
        else $error("mid_twice differs from best bid plus best ask");

    // an empty bid side reports zeros
    a_bid_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_bid_cnt == '0)) |-> ((i_bid_price == '0) && (i_bid_size == '0)))
        else $error("empty bid side shows a level");

    // one event at a time: an accepted beat leaves the input closed in the cycle after it
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken again straight after a beat");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_seq) && $stable(i_mid)))
        else $error("stalled result beat changed");

endmodule

bind order_book_price_levels obpl_check u_obpl_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_evt.valid),
    .i_in_ready  (i_evt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_bid_price (o_res.best_bid_price),
    .i_bid_size  (o_res.best_bid_size),
    .i_ask_price (o_res.best_ask_price),
    .i_mid       (o_res.mid_twice),
    .i_bid_cnt   (o_res.bid_level_count),
    .i_seq       (o_res.sequence_res)
);
